### rtl/core/eba_pkg.sv
package eba_pkg;

  typedef enum logic [4:0] {
    OP_ADD8  = 5'd0,
    OP_ADC8  = 5'd1,
    OP_SUB8  = 5'd2,
    OP_SBC8  = 5'd3,
    OP_CMP8  = 5'd4,
    OP_AND8  = 5'd5,
    OP_OR8   = 5'd6,
    OP_EOR8  = 5'd7,
    OP_BIT8  = 5'd8,
    OP_LD8   = 5'd9,
    OP_NEG8  = 5'd10,
    OP_COM8  = 5'd11,
    OP_INC8  = 5'd12,
    OP_DEC8  = 5'd13,
    OP_CLR8  = 5'd14,
    OP_TST8  = 5'd15,
    OP_ASL8  = 5'd16,
    OP_ASR8  = 5'd17,
    OP_LSR8  = 5'd18,
    OP_ROL8  = 5'd19,
    OP_ROR8  = 5'd20,
    OP_DAA   = 5'd21,
    OP_MUL   = 5'd22,
    OP_SEX   = 5'd23,
    OP_ADDD  = 5'd24,
    OP_SUBD  = 5'd25,
    OP_CMPD  = 5'd26,
    OP_LDD   = 5'd27,
    OP_ANDCC = 5'd28,
    OP_ORCC  = 5'd29
  } op_t;

  // Condition code bit positions
  localparam int CC_C = 0;
  localparam int CC_V = 1;
  localparam int CC_Z = 2;
  localparam int CC_N = 3;
  localparam int CC_H = 5;

  localparam logic [7:0] DAA_LO_FIX = 8'h06;
  localparam logic [7:0] DAA_HI_FIX = 8'h60;
  localparam logic [3:0] BCD_MAX    = 4'h9;
  localparam logic [3:0] BCD_HI_LIM = 4'h8;
  localparam logic [7:0] INC_OVF    = 8'h7f;
  localparam logic [7:0] DEC_OVF    = 8'h80;

  // Decode stage output: adder operands already selected
  typedef struct packed {
    op_t         op;
    logic [15:0] da;
    logic [15:0] db;
    logic [7:0]  cc;
    logic [15:0] x;
    logic [15:0] y;
    logic        sub;
    logic        cin;
  } dec_t;

  // Execute stage output: raw sum and product
  typedef struct packed {
    op_t         op;
    logic [15:0] da;
    logic [15:0] db;
    logic [7:0]  cc;
    logic [15:0] x;
    logic [15:0] y;
    logic [16:0] sum;
    logic [15:0] prod;
  } exe_t;

endpackage

### rtl/core/eba_decode.sv
module eba_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [4:0]       operation,
  input  logic [15:0]      operand_a,
  input  logic [15:0]      operand_b,
  input  logic [7:0]       cc_in,
  input  logic             dn_ready,
  output logic             dn_valid,
  output eba_pkg::dec_t    dec
);

  eba_pkg::dec_t dec_next;
  logic          vld;

  assign in_ready = !vld || dn_ready;
  assign dn_valid = vld;

  always_comb begin
    logic [7:0] a8;
    logic [7:0] fix;
    logic       c;
    a8  = operand_a[7:0];
    c   = cc_in[eba_pkg::CC_C];
    fix = 8'h00;
    if (a8[3:0] > eba_pkg::BCD_MAX || cc_in[eba_pkg::CC_H]) begin
      fix = fix | eba_pkg::DAA_LO_FIX;
    end
    if ((a8[7:4] > eba_pkg::BCD_HI_LIM && a8[3:0] > eba_pkg::BCD_MAX) ||
        a8[7:4] > eba_pkg::BCD_MAX || c) begin
      fix = fix | eba_pkg::DAA_HI_FIX;
    end

    dec_next.op  = eba_pkg::op_t'(operation);
    dec_next.da  = operand_a;
    dec_next.db  = operand_b;
    dec_next.cc  = cc_in;
    dec_next.x   = {8'h00, a8};
    dec_next.y   = {8'h00, operand_b[7:0]};
    dec_next.sub = 1'b0;
    dec_next.cin = 1'b0;
    unique case (eba_pkg::op_t'(operation))
      eba_pkg::OP_ADD8: ;
      eba_pkg::OP_ADC8: dec_next.cin = c;
      eba_pkg::OP_SUB8, eba_pkg::OP_CMP8: dec_next.sub = 1'b1;
      eba_pkg::OP_SBC8: begin
        dec_next.sub = 1'b1;
        dec_next.cin = c;
      end
      eba_pkg::OP_NEG8: begin
        dec_next.x   = 16'h0000;
        dec_next.y   = {8'h00, a8};
        dec_next.sub = 1'b1;
      end
      eba_pkg::OP_INC8: dec_next.y = 16'h0001;
      eba_pkg::OP_DEC8: begin
        dec_next.y   = 16'h0001;
        dec_next.sub = 1'b1;
      end
      eba_pkg::OP_DAA: dec_next.y = {8'h00, fix};
      eba_pkg::OP_ADDD: begin
        dec_next.x = operand_a;
        dec_next.y = operand_b;
      end
      eba_pkg::OP_SUBD, eba_pkg::OP_CMPD: begin
        dec_next.x   = operand_a;
        dec_next.y   = operand_b;
        dec_next.sub = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dec <= dec_next;
    end
  end

endmodule

### rtl/core/eba_exec.sv
module eba_exec (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  eba_pkg::dec_t    dec,
  input  logic             dn_ready,
  output logic             dn_valid,
  output eba_pkg::exe_t    exe
);

  logic        vld;
  logic [16:0] sum_next;
  logic [15:0] prod_next;

  assign up_ready = !vld || dn_ready;
  assign dn_valid = vld;

  // One 17-bit add/subtract; bit 16 (or bit 8 for byte ops) is carry/borrow
  always_comb begin
    if (dec.sub) begin
      sum_next = {1'b0, dec.x} - {1'b0, dec.y} - {16'h0000, dec.cin};
    end else begin
      sum_next = {1'b0, dec.x} + {1'b0, dec.y} + {16'h0000, dec.cin};
    end
    prod_next = {8'h00, dec.da[7:0]} * {8'h00, dec.db[7:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      exe.op   <= dec.op;
      exe.da   <= dec.da;
      exe.db   <= dec.db;
      exe.cc   <= dec.cc;
      exe.x    <= dec.x;
      exe.y    <= dec.y;
      exe.sum  <= sum_next;
      exe.prod <= prod_next;
    end
  end

endmodule

### rtl/core/eba_flags.sv
module eba_flags (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  eba_pkg::exe_t    exe,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [15:0]      result,
  output logic [7:0]       cc_out,
  output logic             writes_back
);

  logic [15:0] result_next;
  logic [7:0]  cc_next;
  logic        wb_next;

  assign up_ready = !out_valid || out_ready;

  always_comb begin
    logic [7:0]  r8;
    logic [15:0] r16;
    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [7:0]  lg;
    logic [7:0]  sh;
    logic        c;
    logic        v_add8;
    logic        v_sub8;
    logic        v_add16;
    logic        v_sub16;
    logic        h;
    r8      = exe.sum[7:0];
    r16     = exe.sum[15:0];
    a8      = exe.da[7:0];
    b8      = exe.db[7:0];
    c       = exe.cc[eba_pkg::CC_C];
    v_add8  = (exe.x[7] ^ r8[7]) & (exe.y[7] ^ r8[7]);
    v_sub8  = (exe.x[7] ^ exe.y[7]) & (exe.x[7] ^ r8[7]);
    v_add16 = (exe.x[15] ^ r16[15]) & (exe.y[15] ^ r16[15]);
    v_sub16 = (exe.x[15] ^ exe.y[15]) & (exe.x[15] ^ r16[15]);
    h       = exe.x[4] ^ exe.y[4] ^ r8[4];

    unique case (exe.op)
      eba_pkg::OP_OR8:  lg = a8 | b8;
      eba_pkg::OP_EOR8: lg = a8 ^ b8;
      eba_pkg::OP_LD8:  lg = b8;
      eba_pkg::OP_TST8: lg = a8;
      default:          lg = a8 & b8;
    endcase

    unique case (exe.op)
      eba_pkg::OP_ASL8: sh = {a8[6:0], 1'b0};
      eba_pkg::OP_ROL8: sh = {a8[6:0], c};
      eba_pkg::OP_ASR8: sh = {a8[7], a8[7:1]};
      eba_pkg::OP_ROR8: sh = {c, a8[7:1]};
      default:          sh = {1'b0, a8[7:1]};
    endcase

    cc_next     = exe.cc;
    result_next = 16'h0000;
    wb_next     = 1'b1;

    unique case (exe.op)
      eba_pkg::OP_ADD8, eba_pkg::OP_ADC8: begin
        result_next              = {8'h00, r8};
        cc_next[eba_pkg::CC_N]   = r8[7];
        cc_next[eba_pkg::CC_Z]   = (r8 == 8'h00);
        cc_next[eba_pkg::CC_V]   = v_add8;
        cc_next[eba_pkg::CC_C]   = exe.sum[8];
        cc_next[eba_pkg::CC_H]   = h;
      end
      eba_pkg::OP_SUB8, eba_pkg::OP_SBC8: begin
        result_next              = {8'h00, r8};
        cc_next[eba_pkg::CC_N]   = r8[7];
        cc_next[eba_pkg::CC_Z]   = (r8 == 8'h00);
        cc_next[eba_pkg::CC_V]   = v_sub8;
        cc_next[eba_pkg::CC_C]   = exe.sum[8];
        cc_next[eba_pkg::CC_H]   = h;
      end
      eba_pkg::OP_CMP8, eba_pkg::OP_NEG8: begin
        result_next              = {8'h00, r8};
        cc_next[eba_pkg::CC_N]   = r8[7];
        cc_next[eba_pkg::CC_Z]   = (r8 == 8'h00);
        cc_next[eba_pkg::CC_V]   = v_sub8;
        cc_next[eba_pkg::CC_C]   = exe.sum[8];
        wb_next                  = (exe.op == eba_pkg::OP_NEG8);
      end
      eba_pkg::OP_AND8, eba_pkg::OP_OR8, eba_pkg::OP_EOR8, eba_pkg::OP_BIT8,
      eba_pkg::OP_LD8, eba_pkg::OP_TST8: begin
        result_next              = {8'h00, lg};
        cc_next[eba_pkg::CC_N]   = lg[7];
        cc_next[eba_pkg::CC_Z]   = (lg == 8'h00);
        cc_next[eba_pkg::CC_V]   = 1'b0;
        wb_next = !(exe.op == eba_pkg::OP_BIT8 || exe.op == eba_pkg::OP_TST8);
      end
      eba_pkg::OP_COM8: begin
        result_next              = {8'h00, ~a8};
        cc_next[eba_pkg::CC_N]   = ~a8[7];
        cc_next[eba_pkg::CC_Z]   = (a8 == 8'hff);
        cc_next[eba_pkg::CC_V]   = 1'b0;
        cc_next[eba_pkg::CC_C]   = 1'b1;
      end
      eba_pkg::OP_INC8, eba_pkg::OP_DEC8: begin
        result_next              = {8'h00, r8};
        cc_next[eba_pkg::CC_N]   = r8[7];
        cc_next[eba_pkg::CC_Z]   = (r8 == 8'h00);
        cc_next[eba_pkg::CC_V]   = (exe.op == eba_pkg::OP_INC8) ?
                                   (a8 == eba_pkg::INC_OVF) :
                                   (a8 == eba_pkg::DEC_OVF);
      end
      eba_pkg::OP_CLR8: begin
        cc_next[eba_pkg::CC_N]   = 1'b0;
        cc_next[eba_pkg::CC_Z]   = 1'b1;
        cc_next[eba_pkg::CC_V]   = 1'b0;
        cc_next[eba_pkg::CC_C]   = 1'b0;
      end
      eba_pkg::OP_ASL8, eba_pkg::OP_ROL8: begin
        result_next              = {8'h00, sh};
        cc_next[eba_pkg::CC_N]   = sh[7];
        cc_next[eba_pkg::CC_Z]   = (sh == 8'h00);
        cc_next[eba_pkg::CC_V]   = a8[7] ^ a8[6];
        cc_next[eba_pkg::CC_C]   = a8[7];
      end
      eba_pkg::OP_ASR8, eba_pkg::OP_LSR8, eba_pkg::OP_ROR8: begin
        result_next              = {8'h00, sh};
        cc_next[eba_pkg::CC_N]   = sh[7];
        cc_next[eba_pkg::CC_Z]   = (sh == 8'h00);
        cc_next[eba_pkg::CC_C]   = a8[0];
      end
      eba_pkg::OP_DAA: begin
        result_next              = {8'h00, r8};
        cc_next[eba_pkg::CC_N]   = r8[7];
        cc_next[eba_pkg::CC_Z]   = (r8 == 8'h00);
        cc_next[eba_pkg::CC_V]   = 1'b0;
        cc_next[eba_pkg::CC_C]   = c | exe.sum[8];
      end
      eba_pkg::OP_MUL: begin
        result_next              = exe.prod;
        cc_next[eba_pkg::CC_Z]   = (exe.prod == 16'h0000);
        cc_next[eba_pkg::CC_C]   = exe.prod[7];
      end
      eba_pkg::OP_SEX: begin
        result_next              = {{8{b8[7]}}, b8};
        cc_next[eba_pkg::CC_N]   = b8[7];
        cc_next[eba_pkg::CC_Z]   = (b8 == 8'h00);
      end
      eba_pkg::OP_ADDD: begin
        result_next              = r16;
        cc_next[eba_pkg::CC_N]   = r16[15];
        cc_next[eba_pkg::CC_Z]   = (r16 == 16'h0000);
        cc_next[eba_pkg::CC_V]   = v_add16;
        cc_next[eba_pkg::CC_C]   = exe.sum[16];
      end
      eba_pkg::OP_SUBD, eba_pkg::OP_CMPD: begin
        result_next              = r16;
        cc_next[eba_pkg::CC_N]   = r16[15];
        cc_next[eba_pkg::CC_Z]   = (r16 == 16'h0000);
        cc_next[eba_pkg::CC_V]   = v_sub16;
        cc_next[eba_pkg::CC_C]   = exe.sum[16];
        wb_next                  = (exe.op == eba_pkg::OP_SUBD);
      end
      eba_pkg::OP_LDD: begin
        result_next              = exe.db;
        cc_next[eba_pkg::CC_N]   = exe.db[15];
        cc_next[eba_pkg::CC_Z]   = (exe.db == 16'h0000);
        cc_next[eba_pkg::CC_V]   = 1'b0;
      end
      eba_pkg::OP_ANDCC: begin
        cc_next                  = exe.cc & b8;
        result_next              = {8'h00, exe.cc & b8};
        wb_next                  = 1'b0;
      end
      eba_pkg::OP_ORCC: begin
        cc_next                  = exe.cc | b8;
        result_next              = {8'h00, exe.cc | b8};
        wb_next                  = 1'b0;
      end
      default: begin
        // undefined operation codes: no result, flags untouched
        wb_next                  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      result      <= result_next;
      cc_out      <= cc_next;
      writes_back <= wb_next;
    end
  end

endmodule

### rtl/core/eight_bit_alu_with_condition_codes.sv
// channel | valid     | ready     | payload
// --------+-----------+-----------+-------------------------------------------
// input   | in_valid  | in_ready  | operation, operand_a, operand_b, cc_in
// output  | out_valid | out_ready | result, cc_out, writes_back
//
// Three register stages: operand select, add/subtract and 8x8 multiply,
// flag and result formation. One item per cycle while the output is not stalled.
// Each stage holds its item while the next one is full and stalled, so an
// input transfer can still happen while a result waits at the output.
// Synchronous reset clears the valid bits only; no state survives an item.
module eight_bit_alu_with_condition_codes (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  operation,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [7:0]  cc_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] result,
  output logic [7:0]  cc_out,
  output logic        writes_back
);

  eba_pkg::dec_t dec;
  eba_pkg::exe_t exe;
  logic          dec_valid;
  logic          dec_ready;
  logic          exe_valid;
  logic          exe_ready;

  eba_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .cc_in     (cc_in),
    .dn_ready  (dec_ready),
    .dn_valid  (dec_valid),
    .dec       (dec)
  );

  eba_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .dec      (dec),
    .dn_ready (exe_ready),
    .dn_valid (exe_valid),
    .exe      (exe)
  );

  eba_flags u_flags (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (exe_valid),
    .up_ready    (exe_ready),
    .exe         (exe),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .result      (result),
    .cc_out      (cc_out),
    .writes_back (writes_back)
  );

endmodule

### rtl/core/eba_checker.sv
module eba_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] result,
  input logic [7:0]  cc_out,
  input logic        writes_back
);

  // An empty output stage means every stage can take a transfer
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output stage");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

  // With the output draining, an accepted item moves through the decode, execute and flag registers to the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(result) && $stable(cc_out) && $stable(writes_back)))
    else $error("stalled result changed");

endmodule

bind eight_bit_alu_with_condition_codes eba_checker u_eba_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result      (result),
  .cc_out      (cc_out),
  .writes_back (writes_back)
);

### tb/tb_eight_bit_alu_with_condition_codes.sv
`timescale 1ns / 100ps

module tb_eight_bit_alu_with_condition_codes;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 48;

  localparam logic [4:0] OP_RSVD30 = 5'd30;
  localparam logic [4:0] OP_RSVD31 = 5'd31;

  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  cc;
    logic        wb;
  } alu_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  operation = '0;
  logic [15:0] operand_a = '0;
  logic [15:0] operand_b = '0;
  logic [7:0]  cc_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] result;
  logic [7:0]  cc_out;
  logic        writes_back;

  alu_out_t expected_alu_q[$];
  alu_out_t head_exp;
  int error_count = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_id = 0;
  int stall_seen = 0;
  int stall_left = 0;

  always #4 clk = ~clk;

  eight_bit_alu_with_condition_codes uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .cc_in      (cc_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result     (result),
    .cc_out     (cc_out),
    .writes_back(writes_back)
  );

  function automatic logic [7:0] with_nz8(input logic [7:0] cc, input logic [7:0] r);
    cc[eba_pkg::CC_N] = r[7];
    cc[eba_pkg::CC_Z] = (r == 8'h00);
    return cc;
  endfunction

  function automatic logic [7:0] with_nz16(input logic [7:0] cc, input logic [15:0] r);
    cc[eba_pkg::CC_N] = r[15];
    cc[eba_pkg::CC_Z] = (r == 16'h0000);
    return cc;
  endfunction

  function automatic alu_out_t predict_alu(input logic [4:0] opcode, input logic [15:0] da,
                                           input logic [15:0] db, input logic [7:0] cc_i);
    logic [7:0]  a, b, x, y, r8, fix;
    logic [8:0]  s9;
    logic [16:0] s17;
    logic [15:0] r16;
    logic [7:0]  cc;
    logic        cy, bin;
    alu_out_t    o;
    a = da[7:0];
    b = db[7:0];
    cc = cc_i;
    cy = cc_i[eba_pkg::CC_C];
    r8 = 8'h00;
    r16 = 16'h0000;
    o.wb = 1'b1;
    unique case (opcode)
      eba_pkg::OP_ADD8, eba_pkg::OP_ADC8: begin
        s9 = {1'b0, a} + {1'b0, b} +
             ((opcode == eba_pkg::OP_ADC8) ? {8'h00, cy} : 9'h000);
        r8 = s9[7:0];
        cc = with_nz8(cc, r8);
        cc[eba_pkg::CC_V] = (a[7] ^ r8[7]) & (b[7] ^ r8[7]);
        cc[eba_pkg::CC_C] = s9[8];
        cc[eba_pkg::CC_H] = a[4] ^ b[4] ^ r8[4];
      end
      eba_pkg::OP_SUB8, eba_pkg::OP_SBC8, eba_pkg::OP_CMP8, eba_pkg::OP_NEG8: begin
        // negate is zero minus the operand
        x = (opcode == eba_pkg::OP_NEG8) ? 8'h00 : a;
        y = (opcode == eba_pkg::OP_NEG8) ? a : b;
        bin = (opcode == eba_pkg::OP_SBC8) ? cy : 1'b0;
        s9 = {1'b0, x} - {1'b0, y} - {8'h00, bin};
        r8 = s9[7:0];
        cc = with_nz8(cc, r8);
        cc[eba_pkg::CC_V] = (x[7] ^ y[7]) & (x[7] ^ r8[7]);
        cc[eba_pkg::CC_C] = s9[8];
        if (opcode == eba_pkg::OP_SUB8 || opcode == eba_pkg::OP_SBC8)
          cc[eba_pkg::CC_H] = x[4] ^ y[4] ^ r8[4];
        if (opcode == eba_pkg::OP_CMP8) o.wb = 1'b0;
      end
      eba_pkg::OP_AND8, eba_pkg::OP_OR8, eba_pkg::OP_EOR8, eba_pkg::OP_BIT8,
      eba_pkg::OP_LD8, eba_pkg::OP_TST8: begin
        unique case (opcode)
          eba_pkg::OP_OR8:  r8 = a | b;
          eba_pkg::OP_EOR8: r8 = a ^ b;
          eba_pkg::OP_LD8:  r8 = b;
          eba_pkg::OP_TST8: r8 = a;
          default:          r8 = a & b;
        endcase
        cc = with_nz8(cc, r8);
        cc[eba_pkg::CC_V] = 1'b0;
        if (opcode == eba_pkg::OP_BIT8 || opcode == eba_pkg::OP_TST8) o.wb = 1'b0;
      end
      eba_pkg::OP_COM8: begin
        r8 = ~a;
        cc = with_nz8(cc, r8);
        cc[eba_pkg::CC_V] = 1'b0;
        cc[eba_pkg::CC_C] = 1'b1;
      end
      eba_pkg::OP_INC8: begin
        r8 = a + 8'h01;
        cc = with_nz8(cc, r8);
        cc[eba_pkg::CC_V] = (a == 8'h7F);
      end
      eba_pkg::OP_DEC8: begin
        r8 = a - 8'h01;
        cc = with_nz8(cc, r8);
        cc[eba_pkg::CC_V] = (a == 8'h80);
      end
      eba_pkg::OP_CLR8: begin
        r8 = 8'h00;
        cc[eba_pkg::CC_N] = 1'b0;
        cc[eba_pkg::CC_V] = 1'b0;
        cc[eba_pkg::CC_C] = 1'b0;
        cc[eba_pkg::CC_Z] = 1'b1;
      end
      eba_pkg::OP_ASL8, eba_pkg::OP_ROL8: begin
        r8 = {a[6:0], (opcode == eba_pkg::OP_ROL8) ? cy : 1'b0};
        cc = with_nz8(cc, r8);
        cc[eba_pkg::CC_C] = a[7];
        cc[eba_pkg::CC_V] = a[7] ^ a[6];
      end
      eba_pkg::OP_ASR8, eba_pkg::OP_LSR8, eba_pkg::OP_ROR8: begin
        unique case (opcode)
          eba_pkg::OP_ASR8: r8 = {a[7], a[7:1]};
          eba_pkg::OP_LSR8: r8 = {1'b0, a[7:1]};
          default:          r8 = {cy, a[7:1]};
        endcase
        cc = with_nz8(cc, r8);
        cc[eba_pkg::CC_C] = a[0];
      end
      eba_pkg::OP_DAA: begin
        fix = 8'h00;
        if (a[3:0] > 4'h9 || cc_i[eba_pkg::CC_H]) fix[3:0] = 4'h6;
        if ((a[7:4] > 4'h8 && a[3:0] > 4'h9) || a[7:4] > 4'h9 || cy) fix[7:4] = 4'h6;
        s9 = {1'b0, a} + {1'b0, fix};
        r8 = s9[7:0];
        cc = with_nz8(cc, r8);
        cc[eba_pkg::CC_V] = 1'b0;
        cc[eba_pkg::CC_C] = cy | s9[8];
      end
      eba_pkg::OP_MUL: begin
        r16 = {8'h00, a} * {8'h00, b};
        cc[eba_pkg::CC_Z] = (r16 == 16'h0000);
        cc[eba_pkg::CC_C] = r16[7];
      end
      eba_pkg::OP_SEX: begin
        r16 = {{8{b[7]}}, b};
        cc = with_nz16(cc, r16);
      end
      eba_pkg::OP_ADDD: begin
        s17 = {1'b0, da} + {1'b0, db};
        r16 = s17[15:0];
        cc = with_nz16(cc, r16);
        cc[eba_pkg::CC_V] = (da[15] ^ r16[15]) & (db[15] ^ r16[15]);
        cc[eba_pkg::CC_C] = s17[16];
      end
      eba_pkg::OP_SUBD, eba_pkg::OP_CMPD: begin
        s17 = {1'b0, da} - {1'b0, db};
        r16 = s17[15:0];
        cc = with_nz16(cc, r16);
        cc[eba_pkg::CC_V] = (da[15] ^ db[15]) & (da[15] ^ r16[15]);
        cc[eba_pkg::CC_C] = s17[16];
        if (opcode == eba_pkg::OP_CMPD) o.wb = 1'b0;
      end
      eba_pkg::OP_LDD: begin
        r16 = db;
        cc = with_nz16(cc, r16);
        cc[eba_pkg::CC_V] = 1'b0;
      end
      eba_pkg::OP_ANDCC, eba_pkg::OP_ORCC: begin
        cc = (opcode == eba_pkg::OP_ANDCC) ? (cc_i & b) : (cc_i | b);
        r8 = cc;
        o.wb = 1'b0;
      end
      default: o.wb = 1'b0;
    endcase
    unique case (opcode)
      eba_pkg::OP_MUL, eba_pkg::OP_SEX, eba_pkg::OP_ADDD, eba_pkg::OP_SUBD,
      eba_pkg::OP_CMPD, eba_pkg::OP_LDD: o.result = r16;
      default: o.result = {8'h00, r8};
    endcase
    o.cc = cc;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    error_count++;
    $display("mismatch on %s: got %h, want %h at %0t", what, got, want, $time);
  endtask

  // Offer one item and hold it until the transfer.
  task automatic send_alu_op(input logic [4:0] opcode, input logic [15:0] da,
                             input logic [15:0] db, input logic [7:0] cc_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= opcode;
    operand_a <= da;
    operand_b <= db;
    cc_in     <= cc_i;
    do @(posedge clk); while (!in_ready);
    expected_alu_q.push_back(predict_alu(opcode, da, db, cc_i));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_alu_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_operand();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(7))
      0: w[7:0] = 8'h00;
      1: w[7:0] = 8'h7F;
      2: w[7:0] = 8'h80;
      3: w[7:0] = 8'hFF;
      4: w = w[0] ? 16'h8000 : 16'h7FFF;
      5: w = w[0] ? 16'hFFFF : 16'h0000;
      default: ;
    endcase
    return w;
  endfunction

  task automatic test_each_operation();
    send_alu_op(eba_pkg::OP_ADD8,  16'h00FF, 16'h0001, 8'h00);
    send_alu_op(eba_pkg::OP_ADC8,  16'h007F, 16'h0000, 8'h01);
    send_alu_op(eba_pkg::OP_SUB8,  16'h0000, 16'h0001, 8'h00);
    send_alu_op(eba_pkg::OP_SBC8,  16'h0080, 16'h0000, 8'h01);
    send_alu_op(eba_pkg::OP_CMP8,  16'h0080, 16'h007F, 8'hFF);
    send_alu_op(eba_pkg::OP_AND8,  16'hFFFF, 16'h0000, 8'hFF);
    send_alu_op(eba_pkg::OP_OR8,   16'h0000, 16'h0080, 8'h00);
    send_alu_op(eba_pkg::OP_EOR8,  16'h00FF, 16'h00FF, 8'h02);
    send_alu_op(eba_pkg::OP_BIT8,  16'h0080, 16'h00FF, 8'h00);
    send_alu_op(eba_pkg::OP_LD8,   16'h0000, 16'hFF80, 8'h06);
    send_alu_op(eba_pkg::OP_NEG8,  16'h0000, 16'h0000, 8'hFF);
    send_alu_op(eba_pkg::OP_NEG8,  16'h0080, 16'h0000, 8'h00);
    send_alu_op(eba_pkg::OP_COM8,  16'h00FF, 16'h0000, 8'h00);
    send_alu_op(eba_pkg::OP_INC8,  16'h007F, 16'h0000, 8'h00);
    send_alu_op(eba_pkg::OP_DEC8,  16'h0080, 16'h0000, 8'h00);
    send_alu_op(eba_pkg::OP_CLR8,  16'hFFFF, 16'hFFFF, 8'hFF);
    send_alu_op(eba_pkg::OP_TST8,  16'h0000, 16'h0000, 8'hFF);
    send_alu_op(eba_pkg::OP_ASL8,  16'h00C0, 16'h0000, 8'h00);
    send_alu_op(eba_pkg::OP_ASR8,  16'h0081, 16'h0000, 8'h00);
    send_alu_op(eba_pkg::OP_LSR8,  16'h0001, 16'h0000, 8'h08);
    send_alu_op(eba_pkg::OP_ROL8,  16'h0080, 16'h0000, 8'h01);
    send_alu_op(eba_pkg::OP_ROR8,  16'h0001, 16'h0000, 8'h01);
    // low digit over nine, half carry, high digit over nine, carry in
    send_alu_op(eba_pkg::OP_DAA,   16'h009A, 16'h0000, 8'h00);
    send_alu_op(eba_pkg::OP_DAA,   16'h0000, 16'h0000, 8'h20);
    send_alu_op(eba_pkg::OP_DAA,   16'h00A0, 16'h0000, 8'h00);
    send_alu_op(eba_pkg::OP_DAA,   16'h0000, 16'h0000, 8'h01);
    send_alu_op(eba_pkg::OP_MUL,   16'hFFFF, 16'hFFFF, 8'h00);
    send_alu_op(eba_pkg::OP_MUL,   16'h0080, 16'h0001, 8'hFF);
    send_alu_op(eba_pkg::OP_SEX,   16'h0000, 16'h0080, 8'h03);
    send_alu_op(eba_pkg::OP_ADDD,  16'h7FFF, 16'h0001, 8'h00);
    send_alu_op(eba_pkg::OP_SUBD,  16'h8000, 16'h0001, 8'h00);
    send_alu_op(eba_pkg::OP_CMPD,  16'h0000, 16'hFFFF, 8'hFF);
    send_alu_op(eba_pkg::OP_LDD,   16'h0000, 16'h8000, 8'h06);
    send_alu_op(eba_pkg::OP_ANDCC, 16'hFFFF, 16'h0000, 8'hFF);
    send_alu_op(eba_pkg::OP_ORCC,  16'h0000, 16'h00FF, 8'h00);
    send_alu_op(OP_RSVD30, 16'hFFFF, 16'hFFFF, 8'hA5);
    send_alu_op(OP_RSVD31, 16'h1234, 16'h5678, 8'h5A);
  endtask

  task automatic test_random_ops(input int count);
    for (int i = 0; i < count; i++)
      send_alu_op(5'($urandom_range(31)), pick_operand(), pick_operand(), 8'($urandom));
  endtask

  // Stall the output while the sender keeps offering.
  task automatic test_output_backpressure();
    stall_id <= stall_id + 1;
    test_random_ops(30);
  endtask

  always @(posedge clk) begin
    if (stall_id != stall_seen) begin
      stall_seen = stall_id;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_alu_q.size() == 0) begin
        report_mismatch("result with no pending item", result, 16'h0000);
      end else begin
        head_exp = expected_alu_q.pop_front();
        if (result !== head_exp.result) report_mismatch("result", result, head_exp.result);
        if (cc_out !== head_exp.cc)
          report_mismatch("cc_out", {8'h00, cc_out}, {8'h00, head_exp.cc});
        if (writes_back !== head_exp.wb)
          report_mismatch("writes_back", {15'h0000, writes_back}, {15'h0000, head_exp.wb});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 6;
    recv_idle_pct <= 84;
    test_each_operation();
    test_random_ops(600);
    drain_results();

    send_idle_pct = 84;
    recv_idle_pct <= 6;
    test_random_ops(600);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    test_output_backpressure();
    test_random_ops(580);
    drain_results();

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
